/* sv/csem_pkg.sv */
`default_nettype none
package csem_pkg;

  localparam int QueueDepth = 16;
  localparam int PtrW       = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int OccW       = $clog2(QueueDepth + 1);

  localparam int CmdW    = 2;
  localparam int IdW     = 8;
  localparam int CountW  = 7;
  localparam int ActionW = 3;

  localparam logic [CountW-1:0] CountMax = 7'd127;

  typedef enum logic [CmdW-1:0] {
    CMD_WAIT   = 2'd0,
    CMD_SIGNAL = 2'd1,
    CMD_DELETE = 2'd2
  } cmd_e;

  typedef enum logic [ActionW-1:0] {
    ACT_DONE    = 3'd0,
    ACT_BLOCKED = 3'd1,
    ACT_READY   = 3'd2,
    ACT_RESUME  = 3'd3,
    ACT_FULL    = 3'd4
  } action_e;

  // controller -> datapath
  typedef struct packed {
    logic load;   // capture the request payload
    logic step;   // execute one result of the held command
  } csem_ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic more;   // delete still has waiters after this result
  } csem_sts_t;

endpackage
`default_nettype wire

/* sv/csem_req_if.sv */
`default_nettype none
interface csem_req_if;
  import csem_pkg::*;

  logic            valid;
  logic            ready;
  logic [CmdW-1:0] cmd;
  logic [IdW-1:0]  caller_id;

  modport source (output valid, output cmd, output caller_id, input ready);
  modport sink   (input valid, input cmd, input caller_id, output ready);
endinterface
`default_nettype wire

/* sv/csem_rsp_if.sv */
`default_nettype none
interface csem_rsp_if;
  import csem_pkg::*;

  logic               valid;
  logic               ready;
  logic [ActionW-1:0] action;
  logic [IdW-1:0]     target_id;
  logic               count_saturated;
  logic               last;

  modport source (output valid, output action, output target_id,
                  output count_saturated, output last, input ready);
  modport sink   (input valid, input action, input target_id,
                  input count_saturated, input last, output ready);
endinterface
`default_nettype wire

/* sv/csem_cfg_if.sv */
`default_nettype none
interface csem_cfg_if;
  import csem_pkg::*;

  logic              valid;
  logic              ready;
  logic [CountW-1:0] initial_count;

  modport source (output valid, output initial_count, input ready);
  modport sink   (input valid, input initial_count, output ready);
endinterface
`default_nettype wire

/* sv/csem_datapath.sv */
`default_nettype none
module csem_datapath (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire csem_pkg::csem_ctl_t           ctl_i,
  output      csem_pkg::csem_sts_t           sts_o,
  input  wire logic [csem_pkg::CmdW-1:0]     cmd_i,
  input  wire logic [csem_pkg::IdW-1:0]      caller_id_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [csem_pkg::CountW-1:0]   cfg_count_i,
  output      logic [csem_pkg::ActionW-1:0]  action_o,
  output      logic [csem_pkg::IdW-1:0]      target_id_o,
  output      logic                          count_saturated_o,
  output      logic                          last_o
);
  import csem_pkg::*;

  logic [IdW-1:0]    mem [QueueDepth];
  logic [CountW-1:0] count_q, count_d;
  logic [PtrW-1:0]   head_q, head_d, tail_q, tail_d, head_nxt, tail_nxt;
  logic [OccW-1:0]   occ_q, occ_d;
  logic [CmdW-1:0]   cmd_q;
  logic [IdW-1:0]    caller_q;
  logic              push;
  action_e           act_d;
  logic [IdW-1:0]    tid_d;
  logic              sat_d, last_d;
  logic [IdW-1:0]    head_id;

  assign head_id  = mem[head_q];
  assign head_nxt = (head_q == PtrW'(QueueDepth - 1)) ? '0 : head_q + 1'b1;
  assign tail_nxt = (tail_q == PtrW'(QueueDepth - 1)) ? '0 : tail_q + 1'b1;

  assign sts_o.more = (cmd_q == CMD_DELETE) && (occ_q > OccW'(1));

  always_comb begin
    count_d = count_q;
    head_d  = head_q;
    tail_d  = tail_q;
    occ_d   = occ_q;
    push    = 1'b0;
    act_d   = ACT_DONE;
    tid_d   = '0;
    sat_d   = 1'b0;
    last_d  = 1'b1;
    if (cfg_we_i) begin
      // reload the count and empty the queue
      count_d = cfg_count_i;
      head_d  = '0;
      tail_d  = '0;
      occ_d   = '0;
    end else if (ctl_i.step) begin
      unique case (cmd_q)
        CMD_WAIT: begin
          if (count_q != '0) begin
            count_d = count_q - 1'b1;
          end else if (occ_q == OccW'(QueueDepth)) begin
            act_d = ACT_FULL;
          end else begin
            push   = 1'b1;
            tail_d = tail_nxt;
            occ_d  = occ_q + 1'b1;
            act_d  = ACT_BLOCKED;
            tid_d  = caller_q;
          end
        end
        CMD_SIGNAL: begin
          if (occ_q != '0) begin
            head_d = head_nxt;
            occ_d  = occ_q - 1'b1;
            act_d  = ACT_READY;
            tid_d  = head_id;
          end else if (count_q == CountMax) begin
            sat_d = 1'b1;
          end else begin
            count_d = count_q + 1'b1;
          end
        end
        CMD_DELETE: begin
          if (occ_q != '0) begin
            act_d  = ACT_RESUME;
            tid_d  = head_id;
            occ_d  = occ_q - 1'b1;
            last_d = (occ_q == OccW'(1));
            if (occ_q == OccW'(1)) begin
              head_d = '0;
              tail_d = '0;
            end else begin
              head_d = head_nxt;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      head_q  <= '0;
      tail_q  <= '0;
      occ_q   <= '0;
    end else begin
      count_q <= count_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      occ_q   <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q    <= cmd_i;
      caller_q <= caller_id_i;
    end
    if (ctl_i.step) begin
      action_o          <= act_d;
      target_id_o       <= tid_d;
      count_saturated_o <= sat_d;
      last_o            <= last_d;
    end
    if (push) begin
      mem[tail_q] <= caller_q;
    end
  end

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OccW'(QueueDepth))
    else $error("queue occupancy beyond depth");

  a_units_or_waiters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != '0) |-> (occ_q == '0))
    else $error("units available while waiters are queued");

  a_delete_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.step && !cfg_we_i && cmd_q == CMD_DELETE && occ_q == OccW'(1))
      |=> (occ_q == '0 && head_q == '0 && tail_q == '0))
    else $error("queue not cleared after final resume");

endmodule
`default_nettype wire

/* sv/csem_ctrl.sv */
`default_nettype none
module csem_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 req_valid_i,
  output      logic                 req_ready_o,
  output      logic                 rsp_valid_o,
  input  wire logic                 rsp_ready_i,
  input  wire csem_pkg::csem_sts_t  sts_i,
  output      csem_pkg::csem_ctl_t  ctl_o
);
  import csem_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || rsp_ready_i;
  assign req_ready_o = (state_q == ST_IDLE);
  assign rsp_valid_o = out_valid_q;

  always_comb begin
    state_d    = state_q;
    ctl_o.load = 1'b0;
    ctl_o.step = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          ctl_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // hold while the previous result waits to transfer
        if (out_free) begin
          ctl_o.step = 1'b1;
          if (!sts_i.more) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctl_o.step) begin
      out_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_o) |=> (state_q == ST_EXEC))
    else $error("accepted request did not start execution");

  a_step_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.step |=> out_valid_q)
    else $error("executed result not presented");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC && out_valid_q && !rsp_ready_i)
      |=> (state_q == ST_EXEC && out_valid_q))
    else $error("execution advanced over an untaken result");

endmodule
`default_nettype wire

/* sv/counting_semaphore_wait_queue.sv */
// A request is accepted in the idle state; its result is registered in execute.
// Each command passes through accept, then execute; the next request waits for idle.
// Delete emits one resume per cycle from the queue head unless the output stalls.
// The single output register sets the stall point; results wait there for the sink.
// Reset: count, queue pointers and occupancy clear to zero; queue storage is not cleared.
`default_nettype none
module counting_semaphore_wait_queue (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  csem_req_if.sink  req,
  csem_rsp_if.source rsp,
  csem_cfg_if.sink  cfg
);
  import csem_pkg::*;

  csem_ctl_t ctl;
  csem_sts_t sts;
  logic      cfg_we;

  assign cfg.ready = 1'b1;
  assign cfg_we    = cfg.valid;

  csem_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req.valid),
    .req_ready_o (req.ready),
    .rsp_valid_o (rsp.valid),
    .rsp_ready_i (rsp.ready),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  csem_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .ctl_i             (ctl),
    .sts_o             (sts),
    .cmd_i             (req.cmd),
    .caller_id_i       (req.caller_id),
    .cfg_we_i          (cfg_we),
    .cfg_count_i       (cfg.initial_count),
    .action_o          (rsp.action),
    .target_id_o       (rsp.target_id),
    .count_saturated_o (rsp.count_saturated),
    .last_o            (rsp.last)
  );

endmodule
`default_nettype wire
